@@ rtl/tnjb_pkg.sv @@
// Shared types, widths and codes of the tick-numbered jitter buffer.
package tnjb_pkg;

    // Field widths
    localparam int TICK_W     = 32;
    localparam int CMD_W      = 64;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 7;

    // Lead and gap are 7-bit, so live entries sit within 127 ticks ahead of
    // the last processed tick; one presence flag per tick value mod 128
    localparam int DIST_W    = 7;
    localparam int PRES_N    = 128;
    localparam int GRP_SEL_W = 3;
    localparam int GRP_IDX_W = 4;
    localparam int GRP_N     = 8;
    localparam int GRP_W     = 16;

    // Parameter defaults
    localparam int WINDOW_DEF   = 128;
    localparam int CMD_BITS_DEF = 64;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] LEAD_RESET = 7'd120;
    localparam logic [CFG_DATA_W-1:0] GAP_RESET  = 7'd8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP  = 8'd1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_STORED    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_STALE     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FAR       = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DELIVERED = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOTHING   = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_SKIPPED   = 3'd5;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic arr_init;
        logic classify;
        logic store;
        logic deliver;
        logic take_cmd;
        logic set_nothing;
        logic resolve;
        logic out_load;
    } tnjb_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic started;
        logic hit;
        logic out_free;
    } tnjb_sts_t;

endpackage

@@ rtl/tnjb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tnjb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/tnjb_find.sv @@
// Three-stage circular find-first over the presence flags.
module tnjb_find
    import tnjb_pkg::*;
(
    input  logic              clk,
    input  logic [PRES_N-1:0] pres,
    input  logic [DIST_W-1:0] start,
    output logic              found,
    output logic [DIST_W-1:0] offset
);

    logic [2*PRES_N-1:0] dbl;
    logic [PRES_N-1:0]   rot_next;
    logic [PRES_N-1:0]   rot_reg;
    logic [GRP_N-1:0]    any_next;
    logic [GRP_N-1:0]    any_reg;
    logic [GRP_IDX_W-1:0] off_next [GRP_N];
    logic [GRP_IDX_W-1:0] off_reg  [GRP_N];
    logic                found_next;
    logic                found_reg;
    logic [DIST_W-1:0]   offset_next;
    logic [DIST_W-1:0]   offset_reg;

    // Stage 1: rotate so that bit 0 is the start position
    assign dbl      = {pres, pres} >> start;
    assign rot_next = dbl[PRES_N-1:0];

    // Stage 2: lowest set bit of each group
    always_comb
    begin
        for (int g = 0; g < GRP_N; g++)
        begin
            any_next[g] = |rot_reg[g*GRP_W +: GRP_W];
            off_next[g] = '0;
            for (int i = GRP_W - 1; i >= 0; i--)
            begin
                if (rot_reg[g*GRP_W + i])
                begin
                    off_next[g] = GRP_IDX_W'(i);
                end
            end
        end
    end

    // Stage 3: first group that holds a set bit
    always_comb
    begin
        logic [GRP_SEL_W-1:0] sel;
        sel = '0;
        for (int g = GRP_N - 1; g >= 0; g--)
        begin
            if (any_reg[g])
            begin
                sel = GRP_SEL_W'(g);
            end
        end
        found_next  = |any_reg;
        offset_next = {sel, off_reg[sel]};
    end

    always_ff @(posedge clk)
    begin
        rot_reg    <= rot_next;
        any_reg    <= any_next;
        off_reg    <= off_next;
        found_reg  <= found_next;
        offset_reg <= offset_next;
    end

    assign found  = found_reg;
    assign offset = offset_reg;

endmodule

@@ rtl/tnjb_dp.sv @@
// Datapath: tick state, presence flags, command store, limits and result registers.
module tnjb_dp
    import tnjb_pkg::*;
#(
    parameter int WINDOW   = WINDOW_DEF,
    parameter int CMD_BITS = CMD_BITS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [TICK_W-1:0]     tick_number,
    input  logic [CMD_W-1:0]      cmd_in,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [STATUS_W-1:0]   status,
    output logic [CMD_W-1:0]      cmd_out,
    output logic [TICK_W-1:0]     processed_tick,
    input  tnjb_cmd_t             cmd,
    output tnjb_sts_t             sts
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam logic [SLOT_W:0] WIN_V = (SLOT_W + 1)'(WINDOW);

    // Control state
    logic [TICK_W-1:0]     last_reg, last_next;
    logic [SLOT_W-1:0]     last_slot_reg, last_slot_next;
    logic                  started_reg, started_next;
    logic [PRES_N-1:0]     pres_reg, pres_next;
    logic [CFG_DATA_W-1:0] lead_reg, lead_next;
    logic [CFG_DATA_W-1:0] gap_reg, gap_next;
    logic                  out_valid_reg, out_valid_next;

    // Payload
    logic [TICK_W-1:0]     tick_reg, tick_next;
    logic [CMD_BITS-1:0]   cmdw_reg, cmdw_next;
    logic [DIST_W-1:0]     d_reg, d_next;
    logic                  arr_ok_reg, arr_ok_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [CMD_BITS-1:0]   res_cmd_reg, res_cmd_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [CMD_W-1:0]      out_cmd_reg, out_cmd_next;
    logic [TICK_W-1:0]     out_tick_reg, out_tick_next;

    // Helpers
    logic [SLOT_W-1:0]   mod_tab  [PRES_N];
    logic                zmod_tab [PRES_N];
    logic [DIST_W-1:0]   start;
    logic [DIST_W-1:0]   b_sel;
    logic [SLOT_W:0]     slot_raw;
    logic [SLOT_W-1:0]   slot_sum;
    logic [PRES_N-1:0]   clr_mask;
    logic [TICK_W-1:0]   d_full;
    logic                find_found;
    logic [DIST_W-1:0]   find_off;
    logic [CMD_BITS-1:0] rd_data;
    logic                ram_we;

    // Small constant tables: distance mod WINDOW, and distance a multiple of it
    for (genvar g = 0; g < PRES_N; g++)
    begin : g_tab
        assign mod_tab[g]  = SLOT_W'(g % WINDOW);
        assign zmod_tab[g] = ((g % WINDOW) == 0);
    end

    assign start = last_reg[DIST_W-1:0] + DIST_W'(1);

    // Slot of last + distance, one add and one conditional subtract
    always_comb
    begin
        if (cmd.store)
        begin
            b_sel = d_reg;
        end
        else if (cmd.resolve)
        begin
            b_sel = find_off;
        end
        else
        begin
            b_sel = DIST_W'(1);
        end
        slot_raw = {1'b0, last_slot_reg} + {1'b0, mod_tab[b_sel]};
        slot_sum = (slot_raw >= WIN_V) ? SLOT_W'(slot_raw - WIN_V) : slot_raw[SLOT_W-1:0];
    end

    // Live entries that share the new arrival's slot get replaced
    always_comb
    begin
        logic [DIST_W-1:0] dj;
        logic [DIST_W:0]   diff;
        logic [DIST_W-1:0] mag;
        dj   = '0;
        diff = '0;
        mag  = '0;
        for (int j = 0; j < PRES_N; j++)
        begin
            dj          = DIST_W'(j) - last_reg[DIST_W-1:0];
            diff        = {1'b0, dj} - {1'b0, d_reg};
            mag         = diff[DIST_W] ? DIST_W'((DIST_W + 1)'(0) - diff) : diff[DIST_W-1:0];
            clr_mask[j] = zmod_tab[mag];
        end
    end

    assign d_full = tick_reg - last_reg;
    assign ram_we = cmd.store && arr_ok_reg;

    tnjb_ram #(
        .WIDTH (CMD_BITS),
        .DEPTH (WINDOW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_sum),
        .wdata (cmdw_reg),
        .raddr (slot_sum),
        .rdata (rd_data)
    );

    tnjb_find u_find (
        .clk    (clk),
        .pres   (pres_reg),
        .start  (start),
        .found  (find_found),
        .offset (find_off)
    );

    // Next-state logic
    always_comb
    begin
        last_next       = last_reg;
        last_slot_next  = last_slot_reg;
        started_next    = started_reg;
        pres_next       = pres_reg;
        lead_next       = lead_reg;
        gap_next        = gap_reg;
        out_valid_next  = out_valid_reg;
        tick_next       = tick_reg;
        cmdw_next       = cmdw_reg;
        d_next          = d_reg;
        arr_ok_next     = arr_ok_reg;
        res_status_next = res_status_reg;
        res_cmd_next    = res_cmd_reg;
        out_status_next = out_status_reg;
        out_cmd_next    = out_cmd_reg;
        out_tick_next   = out_tick_reg;

        if (cmd.load)
        begin
            tick_next    = tick_number;
            cmdw_next    = cmd_in[CMD_BITS-1:0];
            res_cmd_next = '0;
        end

        // First arrival fixes the last processed tick
        if (cmd.arr_init && !started_reg)
        begin
            last_next      = (tick_reg != '0) ? tick_reg - TICK_W'(1) : '0;
            last_slot_next = '0;
            started_next   = 1'b1;
        end

        // Stale / too far / accepted
        if (cmd.classify)
        begin
            d_next = d_full[DIST_W-1:0];
            if ((d_full == '0) || d_full[TICK_W-1])
            begin
                arr_ok_next     = 1'b0;
                res_status_next = STAT_STALE;
            end
            else if ((|d_full[TICK_W-1:DIST_W]) || (d_full[DIST_W-1:0] > lead_reg))
            begin
                arr_ok_next     = 1'b0;
                res_status_next = STAT_FAR;
            end
            else
            begin
                arr_ok_next     = 1'b1;
                res_status_next = STAT_STORED;
            end
        end

        if (ram_we)
        begin
            pres_next = (pres_reg & ~clr_mask) | (PRES_N'(1) << tick_reg[DIST_W-1:0]);
        end

        if (cmd.deliver)
        begin
            pres_next       = pres_reg & ~(PRES_N'(1) << start);
            last_next       = last_reg + TICK_W'(1);
            last_slot_next  = slot_sum;
            res_status_next = STAT_DELIVERED;
        end

        if (cmd.take_cmd)
        begin
            res_cmd_next = rd_data;
        end

        if (cmd.set_nothing)
        begin
            res_status_next = STAT_NOTHING;
        end

        // Skip ahead when the oldest pending item is beyond the gap limit
        if (cmd.resolve)
        begin
            if (find_found && (find_off > gap_reg))
            begin
                last_next       = last_reg + TICK_W'(find_off);
                last_slot_next  = slot_sum;
                res_status_next = STAT_SKIPPED;
            end
            else
            begin
                res_status_next = STAT_NOTHING;
            end
        end

        // Output register
        if (cmd.out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_cmd_next    = CMD_W'(res_cmd_reg);
            out_tick_next   = last_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Configuration writes
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LEAD: lead_next = cfg_data;
                CFG_GAP:  gap_next  = cfg_data;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= '0;
            last_slot_reg <= '0;
            started_reg   <= 1'b0;
            pres_reg      <= '0;
            lead_reg      <= LEAD_RESET;
            gap_reg       <= GAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            last_reg      <= last_next;
            last_slot_reg <= last_slot_next;
            started_reg   <= started_next;
            pres_reg      <= pres_next;
            lead_reg      <= lead_next;
            gap_reg       <= gap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tick_reg       <= tick_next;
        cmdw_reg       <= cmdw_next;
        d_reg          <= d_next;
        arr_ok_reg     <= arr_ok_next;
        res_status_reg <= res_status_next;
        res_cmd_reg    <= res_cmd_next;
        out_status_reg <= out_status_next;
        out_cmd_reg    <= out_cmd_next;
        out_tick_reg   <= out_tick_next;
    end

    assign sts.started  = started_reg;
    assign sts.hit      = pres_reg[start];
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign cmd_out        = out_cmd_reg;
    assign processed_tick = out_tick_reg;

    // The last processed tick never has a pending entry
    a_last_not_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !pres_reg[last_reg[DIST_W-1:0]])
        else $error("pending flag set at last processed tick");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        last_slot_reg < WIN_V)
        else $error("slot index out of range");

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    a_deliver_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.deliver |=> (last_reg == $past(last_reg) + TICK_W'(1)))
        else $error("delivery did not advance by one tick");

    a_started_holds: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |=> started_reg)
        else $error("started flag dropped");

endmodule

@@ rtl/tnjb_ctrl.sv @@
// Controller state machine: sequences one item at a time through the datapath.
module tnjb_ctrl
    import tnjb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      req_type,
    output logic      in_ready,
    input  tnjb_sts_t sts,
    output tnjb_cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ARR   = 4'd1;
    localparam logic [3:0] S_CLASS = 4'd2;
    localparam logic [3:0] S_STORE = 4'd3;
    localparam logic [3:0] S_TICK  = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_F1    = 4'd6;
    localparam logic [3:0] S_F2    = 4'd7;
    localparam logic [3:0] S_F3    = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = req_type ? S_TICK : S_ARR;
                end
            end
            S_ARR:
            begin
                cmd.arr_init = 1'b1;
                state_next   = S_CLASS;
            end
            S_CLASS:
            begin
                cmd.classify = 1'b1;
                state_next   = S_STORE;
            end
            S_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = S_OUT;
            end
            // Deliver, report nothing, or start the oldest-pending search
            S_TICK:
            begin
                if (!sts.started)
                begin
                    cmd.set_nothing = 1'b1;
                    state_next      = S_OUT;
                end
                else if (sts.hit)
                begin
                    cmd.deliver = 1'b1;
                    state_next  = S_RD;
                end
                else
                begin
                    state_next = S_F1;
                end
            end
            S_RD:
            begin
                cmd.take_cmd = 1'b1;
                state_next   = S_OUT;
            end
            S_F1:
            begin
                state_next = S_F2;
            end
            S_F2:
            begin
                state_next = S_F3;
            end
            S_F3:
            begin
                cmd.resolve = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/tick_numbered_input_jitter_buffer.sv @@
// Items go through the controller one at a time; a new item is taken only once the last
// result is loaded. An arrival steps through init, classify and store; a tick with delivery
// through the registered command-store read; a tick that searches for the oldest pending
// item through the 3-stage find-first; a tick before the first arrival goes straight to output.
// A result still held in the output register adds stalls.
// Reset (async, active low) clears pending flags, tick state and output valid; limits
// return to lead 120 and gap 8. The command store needs no clearing pass.
module tick_numbered_input_jitter_buffer
    import tnjb_pkg::*;
#(
    parameter int WINDOW   = WINDOW_DEF,
    parameter int CMD_BITS = CMD_BITS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  req_type,
    input  logic [TICK_W-1:0]     tick_number,
    input  logic [CMD_W-1:0]      cmd_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   status,
    output logic [CMD_W-1:0]      cmd_out,
    output logic [TICK_W-1:0]     processed_tick,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    tnjb_cmd_t cmd;
    tnjb_sts_t sts;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    tnjb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tnjb_dp #(
        .WINDOW   (WINDOW),
        .CMD_BITS (CMD_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick_number    (tick_number),
        .cmd_in         (cmd_in),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .status         (status),
        .cmd_out        (cmd_out),
        .processed_tick (processed_tick),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

@@ tb/tb_tick_numbered_input_jitter_buffer.sv @@
// Self-checking testbench for the tick-numbered jitter buffer: directed and random traffic.
module tb_tick_numbered_input_jitter_buffer;
    import tnjb_pkg::*;

    localparam int SLOTS       = WINDOW_DEF;
    localparam int SETTLE      = 8;      // longest item latency plus margin
    localparam int STALL_LIMIT = 1000;   // cycles without any handshake
    localparam int MAX_WAIT    = 17;
    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    typedef struct {
        logic              kind;
        logic [TICK_W-1:0] tick;
        logic [CMD_W-1:0]  cmd;
    } jb_item_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [CMD_W-1:0]    cmd;
        logic [TICK_W-1:0]   tick;
    } jb_result_t;

    // Clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Block ports
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  req_type = 1'b0;
    logic [TICK_W-1:0]     tick_number = '0;
    logic [CMD_W-1:0]      cmd_in = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [CMD_W-1:0]      cmd_out;
    logic [TICK_W-1:0]     processed_tick;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    tick_numbered_input_jitter_buffer u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .tick_number    (tick_number),
        .cmd_in         (cmd_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .cmd_out        (cmd_out),
        .processed_tick (processed_tick),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Shadow copy of the buffer state
    bit                  held [SLOTS];
    logic [TICK_W-1:0]   held_tick [SLOTS];
    logic [CMD_W-1:0]    held_cmd [SLOTS];
    logic [TICK_W-1:0]   last_done = '0;
    bit                  seen_first = 1'b0;
    logic [CFG_DATA_W-1:0] lead_lim = LEAD_RESET;
    logic [CFG_DATA_W-1:0] gap_lim = GAP_RESET;

    jb_item_t   pending_items [$];
    jb_result_t expected_results [$];
    jb_item_t   cur_item;
    int         errors = 0;

    // Traffic generator state
    logic [TICK_W-1:0] sender_tick = '0;
    logic [TICK_W-1:0] late_ticks [$];

    function automatic bit is_newer(logic [TICK_W-1:0] a, logic [TICK_W-1:0] b);
        logic [TICK_W-1:0] d;
        d = a - b;
        return d != 0 && d < 32'h8000_0000;
    endfunction

    function automatic void drop_stale();
        for (int i = 0; i < SLOTS; i++)
            if (held[i] && !is_newer(held_tick[i], last_done))
                held[i] = 1'b0;
    endfunction

    // Expected result of one item; updates the shadow state
    function automatic jb_result_t buffer_step(jb_item_t it);
        jb_result_t r;
        logic [TICK_W-1:0] want;
        logic [TICK_W-1:0] span;
        logic [TICK_W-1:0] best_dist;
        logic [TICK_W-1:0] best_tick;
        bit found;
        int slot;
        r.status = STAT_NOTHING;
        r.cmd = '0;
        found = 1'b0;
        best_dist = '0;
        best_tick = '0;
        if (it.kind == REQ_ARRIVAL) begin
            if (!seen_first) begin
                last_done = (it.tick != 0) ? it.tick - 32'd1 : '0;
                seen_first = 1'b1;
            end
            if (!is_newer(it.tick, last_done))
                r.status = STAT_STALE;
            else if (it.tick - last_done > TICK_W'(lead_lim))
                r.status = STAT_FAR;
            else begin
                slot = int'(it.tick % SLOTS);
                held[slot] = 1'b1;
                held_tick[slot] = it.tick;
                held_cmd[slot] = it.cmd;
                r.status = STAT_STORED;
            end
        end else if (seen_first) begin
            want = last_done + 32'd1;
            slot = int'(want % SLOTS);
            if (held[slot] && held_tick[slot] == want) begin
                r.cmd = held_cmd[slot];
                held[slot] = 1'b0;
                last_done = want;
                drop_stale();
                r.status = STAT_DELIVERED;
            end else begin
                // serially oldest held command
                for (int i = 0; i < SLOTS; i++) begin
                    if (held[i]) begin
                        span = held_tick[i] - last_done;
                        if (!found || span < best_dist) begin
                            found = 1'b1;
                            best_dist = span;
                            best_tick = held_tick[i];
                        end
                    end
                end
                if (found && best_dist >= 32'd1 && best_dist - 32'd1 > TICK_W'(gap_lim)) begin
                    last_done = best_tick - 32'd1;
                    drop_stale();
                    r.status = STAT_SKIPPED;
                end
            end
        end
        r.tick = last_done;
        return r;
    endfunction

    function automatic logic [CMD_W-1:0] random_cmd();
        int k;
        k = $urandom_range(0, 15);
        if (k == 0)
            return '0;
        if (k == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic void add_arrival(logic [TICK_W-1:0] t, logic [CMD_W-1:0] c);
        jb_item_t it;
        it.kind = REQ_ARRIVAL;
        it.tick = t;
        it.cmd = c;
        pending_items.insert(pending_items.size(), it);
    endfunction

    // tick and command fields are don't-care on a processing tick
    function automatic void add_tick();
        jb_item_t it;
        it.kind = REQ_TICK;
        it.tick = $urandom;
        it.cmd = {$urandom, $urandom};
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic logic [TICK_W-1:0] noise_tick();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return sender_tick + $urandom_range(100, 300);
            2: return sender_tick - $urandom_range(1, 300);
            default: return sender_tick + $urandom_range(0, 127);
        endcase
    endfunction

    // One sender at game rate: losses, late items, resends and noise
    task automatic run_traffic(int n);
        int pushed;
        int k;
        pushed = 0;
        sender_tick = last_done + 32'd1;
        late_ticks.delete();
        while (pushed < n) begin
            k = $urandom_range(0, 99);
            if (k >= 27) begin
                add_arrival(sender_tick, random_cmd());
                pushed++;
            end else if (k >= 12) begin
                late_ticks.insert(late_ticks.size(), sender_tick);
            end
            if (late_ticks.size() != 0 && $urandom_range(0, 2) == 0) begin
                add_arrival(late_ticks.pop_front(), random_cmd());
                pushed++;
            end
            if ($urandom_range(0, 9) == 0) begin
                add_arrival(sender_tick - $urandom_range(0, 8), random_cmd());
                pushed++;
            end
            if ($urandom_range(0, 11) == 0) begin
                add_arrival(noise_tick(), random_cmd());
                pushed++;
            end
            add_tick();
            pushed++;
            if ($urandom_range(0, 7) == 0) begin
                add_tick();
                pushed++;
            end
            sender_tick++;
        end
    endtask

    // Wait until every item is in and every result is out; sampled on the
    // falling edge so that the driver and monitor updates have settled
    task automatic drain();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_LEAD)
            lead_lim = val;
        else
            gap_lim = val;
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_wait(bit calm);
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Item driver
    int send_wait = 0;
    bit send_calm = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            req_type <= 1'b0;
            tick_number <= '0;
            cmd_in <= '0;
            send_wait = 0;
        end else begin
            if (in_valid && in_ready)
                expected_results.insert(expected_results.size(), buffer_step(cur_item));
            if (!in_valid || in_ready) begin
                if (send_wait != 0) begin
                    send_wait--;
                    in_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    cur_item = pending_items.pop_front();
                    req_type <= cur_item.kind;
                    tick_number <= cur_item.tick;
                    cmd_in <= cur_item.cmd;
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        send_calm = !send_calm;
                    send_wait = pick_wait(send_calm);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with receiver stalls
    int recv_wait = 0;
    bit recv_calm = 1'b0;
    jb_result_t want_r;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result at %0t: status %0d cmd %h tick %h",
                                 $time, status, cmd_out, processed_tick);
                end else begin
                    want_r = expected_results.pop_front();
                    if (status !== want_r.status || cmd_out !== want_r.cmd
                        || processed_tick !== want_r.tick) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch at %0t: status %0d/%0d cmd %h/%h tick %h/%h",
                                     $time, want_r.status, status, want_r.cmd, cmd_out,
                                     want_r.tick, processed_tick);
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    recv_calm = !recv_calm;
                recv_wait = pick_wait(recv_calm);
            end else if (recv_wait != 0) begin
                recv_wait--;
            end
            out_ready <= (recv_wait == 0);
        end
    end

    // Watchdog on handshake activity
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout at %0t", $time);
                $display("tick_numbered_input_jitter_buffer test failed");
                $finish;
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        int lead_plan [7];
        int gap_plan [7];
        int size_plan [7];
        logic [TICK_W-1:0] base;
        logic [TICK_W-1:0] first;
        bit wrap_start;
        lead_plan = '{127, 1, 0, 60, 127, -1, 120};
        gap_plan = '{0, 127, 9, 3, 127, -1, 8};
        size_plan = '{200, 200, 40, 200, 200, 200, 200};
        for (int i = 0; i < SLOTS; i++)
            held[i] = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Start either at tick zero or just short of the 32-bit wrap
        wrap_start = $urandom_range(0, 1);
        base = wrap_start ? 32'hFFFF_FFF0 : 32'h0;
        first = wrap_start ? base + 32'd1 : 32'h0;

        add_tick();                                   // tick before any arrival
        add_arrival(first, random_cmd());             // first arrival sets last-done
        add_arrival(base + 32'd1, '1);                // repeated number replaces (wrap start only)
        add_arrival(base + 32'd2, '0);
        add_arrival(base, random_cmd());              // stale
        add_arrival(base + 32'd16, random_cmd());
        add_arrival(base + 32'd120, random_cmd());    // exactly at lead limit
        add_arrival(base + 32'd121, random_cmd());    // one past lead limit
        add_arrival(base + 32'h8000_0000, random_cmd()); // half range away
        add_tick();                                   // deliver
        add_tick();                                   // deliver
        add_tick();                                   // skip, lands just short of the wrap when near it
        add_tick();                                   // deliver after skip, crosses wrap when near it
        add_arrival(base + 32'd25, random_cmd());
        add_tick();                                   // gap equal to limit: no skip
        add_arrival(base + 32'd17, random_cmd());
        add_tick();
        drain();
        run_traffic(250);

        for (int p = 0; p < 7; p++) begin
            drain();
            write_reg(CFG_LEAD, (lead_plan[p] < 0) ? CFG_DATA_W'($urandom_range(1, 127))
                                                   : CFG_DATA_W'(lead_plan[p]));
            write_reg(CFG_GAP, (gap_plan[p] < 0) ? CFG_DATA_W'($urandom_range(0, 127))
                                                 : CFG_DATA_W'(gap_plan[p]));
            run_traffic(size_plan[p]);
        end
        drain();

        if (errors == 0)
            $display("tick_numbered_input_jitter_buffer test passed");
        else
            $display("tick_numbered_input_jitter_buffer test failed");
        $finish;
    end

endmodule
